// ----- rtl/importance_map_greedy_trim_assert.svh -----
// Assertion macros for the greedy trim RTL.
`ifndef IMPORTANCE_MAP_GREEDY_TRIM_ASSERT_SVH
`define IMPORTANCE_MAP_GREEDY_TRIM_ASSERT_SVH
`ifndef SYNTHESIS
`define IMGT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IMGT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IMGT_ASSERT_IMP(lbl, ante, cons)
`define IMGT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/imgt_pkg.sv -----
// Shared constants, codes and command/status types of the greedy trim block.
package imgt_pkg;

  localparam int CW         = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DENS_W     = 16;
  localparam int KEEP_W     = 17;

  localparam logic [KEEP_W-1:0] KEEP_ONE = 17'd65536;

  localparam int MAP_MAX_W_DEF   = 256;
  localparam int MAP_MAX_H_DEF   = 256;
  localparam int PROTECT_MAX_DEF = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHEAP_DENSITY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MASS     = 2'd3;

  localparam logic [CW-1:0]     RST_MAP_WIDTH     = 9'd256;
  localparam logic [CW-1:0]     RST_MAP_HEIGHT    = 9'd256;
  localparam logic [DENS_W-1:0] RST_CHEAP_DENSITY = 16'd128;
  localparam logic [KEEP_W-1:0] RST_KEEP_MASS     = 17'd58982;

  typedef logic [2:0] rect_sel_t;
  localparam rect_sel_t RECT_LEFT   = 3'd0;
  localparam rect_sel_t RECT_TOP    = 3'd1;
  localparam rect_sel_t RECT_RIGHT  = 3'd2;
  localparam rect_sel_t RECT_BOTTOM = 3'd3;
  localparam rect_sel_t RECT_FULL   = 3'd4;

  typedef struct packed {
    logic      load;
    logic      fill;
    logic      box;
    logic      trim_init;
    logic      rd_issue;
    logic [1:0] rd_corner;
    rect_sel_t rd_sel;
    logic      set_total;
    logic      mul;
    logic      eval;
    logic      apply;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic total_zero;
    logic best_found;
  } stat_t;

endpackage

// ----- rtl/imgt_dp.sv -----
// Datapath: summed-area table memory, protect store and trim arithmetic.
module imgt_dp #(
  parameter int MAP_MAX_W   = imgt_pkg::MAP_MAX_W_DEF,
  parameter int MAP_MAX_H   = imgt_pkg::MAP_MAX_H_DEF,
  parameter int PROTECT_MAX = imgt_pkg::PROTECT_MAX_DEF,
  parameter int WEIGHT_BITS = imgt_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  imgt_pkg::cmd_t                cmd,
  output imgt_pkg::stat_t               stat,
  input  logic [imgt_pkg::CW-1:0]       map_width,
  input  logic [imgt_pkg::CW-1:0]       map_height,
  input  logic [imgt_pkg::DENS_W-1:0]   cheap_density,
  input  logic [imgt_pkg::KEEP_W-1:0]   keep_mass,
  input  logic [WEIGHT_BITS-1:0]        weight,
  input  logic [imgt_pkg::CW-1:0]       box_left,
  input  logic [imgt_pkg::CW-1:0]       box_top,
  input  logic [imgt_pkg::CW-1:0]       box_right,
  input  logic [imgt_pkg::CW-1:0]       box_bottom,
  output logic [imgt_pkg::CW-1:0]       win_left,
  output logic [imgt_pkg::CW-1:0]       win_top,
  output logic [imgt_pkg::CW-1:0]       win_right,
  output logic [imgt_pkg::CW-1:0]       win_bottom,
  output logic                          whole_map,
  output logic                          protect_overflow
);
  import imgt_pkg::*;

  localparam int XW     = $clog2(MAP_MAX_W + 1);
  localparam int YW     = $clog2(MAP_MAX_H + 1);
  localparam int STRIDE = MAP_MAX_W + 1;
  localparam int DEPTH  = (MAP_MAX_W + 1) * (MAP_MAX_H + 1);
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = WEIGHT_BITS + $clog2(MAP_MAX_W) + $clog2(MAP_MAX_H);
  localparam int NW     = XW + YW;
  localparam int RW     = (XW > YW) ? XW : YW;
  localparam int WMX    = (XW > CW) ? XW : CW;
  localparam int HMX    = (YW > CW) ? YW : CW;
  localparam int BW     = (RW > CW) ? RW : CW;
  localparam int PCW    = $clog2(PROTECT_MAX + 1);
  localparam int PIW    = (PROTECT_MAX > 1) ? $clog2(PROTECT_MAX) : 1;
  localparam int KTW    = SW + KEEP_W;
  localparam int DTW    = SW + DENS_W;
  localparam int P1W    = SW + NW;
  localparam int P2W    = DTW + RW;
  localparam int MW     = SW + NW + DENS_W + 8;
  localparam int QW     = SW + RW;

  function automatic logic [AW-1:0] sat_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(y) * AW'(STRIDE) + AW'(x);
  endfunction

  // clamped map size and derived limits
  logic [WMX-1:0]    mw_ext;
  logic [HMX-1:0]    mh_ext;
  logic [XW-1:0]     w_use, minw;
  logic [YW-1:0]     h_use, minh;
  logic [KEEP_W-1:0] keep_sat;

  always_comb begin
    mw_ext = WMX'(map_width);
    mh_ext = HMX'(map_height);
    if (mw_ext < WMX'(2)) w_use = XW'(2);
    else if (mw_ext > WMX'(MAP_MAX_W)) w_use = XW'(MAP_MAX_W);
    else w_use = XW'(mw_ext);
    if (mh_ext < HMX'(2)) h_use = YW'(2);
    else if (mh_ext > HMX'(MAP_MAX_H)) h_use = YW'(MAP_MAX_H);
    else h_use = YW'(mh_ext);
    minw = ((w_use >> 3) > XW'(2)) ? (w_use >> 3) : XW'(2);
    minh = ((h_use >> 3) > YW'(2)) ? (h_use >> 3) : YW'(2);
    keep_sat = (keep_mass > KEEP_ONE) ? KEEP_ONE : keep_mass;
  end

  // table memory
  logic [SW-1:0] sat_mem [DEPTH];
  logic [SW-1:0] rd_q;
  logic [AW-1:0] rd_addr;

  // load pipeline
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [SW-1:0] rowsum, rowsum_new, wgt_ext;
  logic          load_ev, wr_pend, wr_row0;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_part;

  assign load_ev    = (cmd.load || cmd.fill) && (row < h_use);
  assign wgt_ext    = cmd.fill ? '0 : SW'(weight);
  assign rowsum_new = ((col == '0) ? '0 : rowsum) + wgt_ext;

  // window and trim state
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [XW-1:0] rx0, rx1, cx;
  logic [YW-1:0] ry0, ry1, cy;
  logic          c_neg;
  logic          rdv_q, rd_neg_q, rd_zero_q, rd_first_q;
  logic [SW-1:0] mass, term, base;
  logic [SW-1:0] kept, diff, bmass;
  logic [KTW-1:0] kt;
  logic [DTW-1:0] cdt;
  logic [NW-1:0]  cells;
  logic [P1W-1:0] p1;
  logic [P2W-1:0] p2;
  logic [QW-1:0]  p3, p4;
  logic           gt, whole, best_found;
  logic [1:0]     best_side;
  logic [RW-1:0]  barea, area;
  logic           room, hit, keep_fail, dens_fail, better, ok;

  // protect store
  logic [CW-1:0]  pb_l [PROTECT_MAX];
  logic [CW-1:0]  pb_t [PROTECT_MAX];
  logic [CW-1:0]  pb_r [PROTECT_MAX];
  logic [CW-1:0]  pb_b [PROTECT_MAX];
  logic [PCW-1:0] pcount;
  logic           overflow;

  // strip / full rectangle of the current selection
  always_comb begin
    rx0 = x0; ry0 = y0; rx1 = x1; ry1 = y1;
    unique case (cmd.rd_sel)
      RECT_LEFT:   rx1 = x0 + XW'(1);
      RECT_TOP:    ry1 = y0 + YW'(1);
      RECT_RIGHT:  rx0 = x1 - XW'(1);
      RECT_BOTTOM: ry0 = y1 - YW'(1);
      RECT_FULL: begin
        rx0 = '0; ry0 = '0; rx1 = w_use; ry1 = h_use;
      end
      default: ;
    endcase
    unique case (cmd.rd_corner)
      2'd0: begin cx = rx1; cy = ry1; c_neg = 1'b0; end
      2'd1: begin cx = rx0; cy = ry1; c_neg = 1'b1; end
      2'd2: begin cx = rx1; cy = ry0; c_neg = 1'b1; end
      default: begin cx = rx0; cy = ry0; c_neg = 1'b0; end
    endcase
  end

  assign rd_addr = cmd.rd_issue ? sat_addr(cx, cy) : sat_addr(col + XW'(1), row);

  // strip tests
  always_comb begin
    if (cmd.rd_sel == RECT_LEFT || cmd.rd_sel == RECT_RIGHT) begin
      area = RW'(y1 - y0);
      room = (x1 - x0) > minw;
    end else begin
      area = RW'(x1 - x0);
      room = (y1 - y0) > minh;
    end
    hit = 1'b0;
    for (int i = 0; i < PROTECT_MAX; i++) begin
      if (PCW'(i) < pcount &&
          BW'(rx0) < BW'(pb_r[i]) && BW'(rx1) > BW'(pb_l[i]) &&
          BW'(ry0) < BW'(pb_b[i]) && BW'(ry1) > BW'(pb_t[i]))
        hit = 1'b1;
    end
    keep_fail = (KTW'(diff) << 16) < kt;
    dens_fail = (MW'(p1) << 8) > MW'(p2);
    better    = !best_found || (p3 < p4);
    ok        = room && !hit && !gt && !keep_fail && !dens_fail && better;
    term      = rd_zero_q ? '0 : rd_q;
    base      = rd_first_q ? '0 : mass;
  end

  always_ff @(posedge clk) begin
    rd_q <= sat_mem[rd_addr];
    if (wr_pend) sat_mem[wr_addr] <= wr_part + (wr_row0 ? '0 : rd_q);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; wr_pend <= 1'b0; rdv_q <= 1'b0;
      pcount <= '0; overflow <= 1'b0; best_found <= 1'b0;
    end else begin
      wr_pend <= load_ev;
      rdv_q   <= cmd.rd_issue;
      if (load_ev) begin
        if (col + XW'(1) == w_use) begin
          col <= '0;
          row <= row + YW'(1);
        end else begin
          col <= col + XW'(1);
        end
      end
      if (cmd.box && box_right > box_left && box_bottom > box_top) begin
        if (pcount < PCW'(PROTECT_MAX)) pcount <= pcount + PCW'(1);
        else overflow <= 1'b1;
      end
      if (cmd.trim_init) best_found <= 1'b0;
      if (cmd.eval && ok) best_found <= 1'b1;
      if (cmd.apply) best_found <= 1'b0;
      if (cmd.emit) begin
        col <= '0; row <= '0; pcount <= '0; overflow <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_ev) begin
      rowsum  <= rowsum_new;
      wr_part <= rowsum_new;
      wr_addr <= sat_addr(col + XW'(1), row + YW'(1));
      wr_row0 <= (row == '0);
    end
    if (cmd.box && box_right > box_left && box_bottom > box_top &&
        pcount < PCW'(PROTECT_MAX)) begin
      pb_l[pcount[PIW-1:0]] <= box_left;
      pb_t[pcount[PIW-1:0]] <= box_top;
      pb_r[pcount[PIW-1:0]] <= box_right;
      pb_b[pcount[PIW-1:0]] <= box_bottom;
    end
    rd_neg_q   <= c_neg;
    rd_zero_q  <= (cx == '0) || (cy == '0);
    rd_first_q <= (cmd.rd_corner == 2'd0);
    if (rdv_q) mass <= rd_neg_q ? base - term : base + term;
    if (cmd.trim_init) begin
      x0 <= '0; y0 <= '0; x1 <= w_use; y1 <= h_use;
    end
    if (cmd.set_total) begin
      kept  <= mass;
      kt    <= KTW'(keep_sat) * KTW'(mass);
      cdt   <= DTW'(cheap_density) * DTW'(mass);
      cells <= NW'(w_use) * NW'(h_use);
      whole <= (mass == '0);
    end
    if (cmd.mul) begin
      p1   <= P1W'(mass) * P1W'(cells);
      p2   <= P2W'(cdt) * P2W'(area);
      p3   <= QW'(mass) * QW'(barea);
      p4   <= QW'(bmass) * QW'(area);
      diff <= kept - mass;
      gt   <= mass > kept;
    end
    if (cmd.eval && ok) begin
      best_side <= cmd.rd_sel[1:0];
      bmass     <= mass;
      barea     <= area;
    end
    if (cmd.apply && best_found) begin
      kept <= kept - bmass;
      unique case (best_side)
        RECT_LEFT[1:0]:  x0 <= x0 + XW'(1);
        RECT_TOP[1:0]:   y0 <= y0 + YW'(1);
        RECT_RIGHT[1:0]: x1 <= x1 - XW'(1);
        default:         y1 <= y1 - YW'(1);
      endcase
    end
  end

  assign stat.load_done  = (row >= h_use);
  assign stat.total_zero = (mass == '0);
  assign stat.best_found = best_found;

  assign win_left         = CW'(x0);
  assign win_top          = CW'(y0);
  assign win_right        = CW'(x1);
  assign win_bottom       = CW'(y1);
  assign whole_map        = whole;
  assign protect_overflow = overflow;

endmodule

// ----- rtl/imgt_ctrl.sv -----
// Controller: sequences loading, zero fill, total read and the trim passes.
module imgt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            func,
  input  logic            last,
  output logic            in_stall,
  input  imgt_pkg::stat_t stat,
  input  logic            out_free,
  output imgt_pkg::cmd_t  cmd
);
  import imgt_pkg::*;

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_FILL      = 4'd1;
  localparam logic [3:0] S_FLUSH     = 4'd2;
  localparam logic [3:0] S_TOT_RD    = 4'd3;
  localparam logic [3:0] S_TOT_WAIT  = 4'd4;
  localparam logic [3:0] S_TOT_SET   = 4'd5;
  localparam logic [3:0] S_EDGE_RD   = 4'd6;
  localparam logic [3:0] S_EDGE_WAIT = 4'd7;
  localparam logic [3:0] S_MUL       = 4'd8;
  localparam logic [3:0] S_EVAL      = 4'd9;
  localparam logic [3:0] S_APPLY     = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] corner, corner_next;
  logic [1:0] side, side_next;

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    state_next  = state;
    corner_next = corner;
    side_next   = side;
    cmd.rd_sel    = {1'b0, side};
    cmd.rd_corner = corner;
    unique case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (func) begin
            cmd.box = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (last) state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (stat.load_done) state_next = S_FLUSH;
        else cmd.fill = 1'b1;
      end
      S_FLUSH: begin
        cmd.trim_init = 1'b1;
        corner_next   = 2'd0;
        state_next    = S_TOT_RD;
      end
      S_TOT_RD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_sel   = RECT_FULL;
        corner_next  = corner + 2'd1;
        if (corner == 2'd3) state_next = S_TOT_WAIT;
      end
      S_TOT_WAIT: state_next = S_TOT_SET;
      S_TOT_SET: begin
        cmd.set_total = 1'b1;
        side_next     = 2'd0;
        corner_next   = 2'd0;
        state_next    = stat.total_zero ? S_DONE : S_EDGE_RD;
      end
      S_EDGE_RD: begin
        cmd.rd_issue = 1'b1;
        corner_next  = corner + 2'd1;
        if (corner == 2'd3) state_next = S_EDGE_WAIT;
      end
      S_EDGE_WAIT: state_next = S_MUL;
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (side == 2'd3) begin
          state_next = S_APPLY;
        end else begin
          side_next  = side + 2'd1;
          state_next = S_EDGE_RD;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        side_next  = 2'd0;
        state_next = stat.best_found ? S_EDGE_RD : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      corner <= 2'd0;
      side   <= 2'd0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
      side   <= side_next;
    end
  end

endmodule

// ----- rtl/importance_map_greedy_trim.sv -----
// Top level: greedy edge trim of an importance map by summed-area table.
// Loading: one map cell or protect box per cycle, no stall while a map loads.
// After the last cell: zero fill of the missing cells, four corner reads for the total,
// then per trim pass four strips, each with four table-port reads and its evaluation, one
// more pass to find no candidate, and the emit; the table read port sets this pace.
// Reset (rst, synchronous): config to defaults, load position and box count cleared.
`include "importance_map_greedy_trim_assert.svh"
module importance_map_greedy_trim #(
  parameter int MAP_MAX_W   = imgt_pkg::MAP_MAX_W_DEF,
  parameter int MAP_MAX_H   = imgt_pkg::MAP_MAX_H_DEF,
  parameter int PROTECT_MAX = imgt_pkg::PROTECT_MAX_DEF,
  parameter int WEIGHT_BITS = imgt_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [imgt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imgt_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [WEIGHT_BITS-1:0]            weight,
  input  logic [imgt_pkg::CW-1:0]           box_left,
  input  logic [imgt_pkg::CW-1:0]           box_top,
  input  logic [imgt_pkg::CW-1:0]           box_right,
  input  logic [imgt_pkg::CW-1:0]           box_bottom,
  input  logic                              last,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imgt_pkg::CW-1:0]           win_left,
  output logic [imgt_pkg::CW-1:0]           win_top,
  output logic [imgt_pkg::CW-1:0]           win_right,
  output logic [imgt_pkg::CW-1:0]           win_bottom,
  output logic                              whole_map,
  output logic                              protect_overflow
);
  import imgt_pkg::*;

  // configuration registers
  logic [CW-1:0]     map_width, map_height;
  logic [DENS_W-1:0] cheap_density;
  logic [KEEP_W-1:0] keep_mass;

  cmd_t  cmd;
  stat_t stat;
  logic  out_free;

  // datapath view of the result
  logic [CW-1:0] dp_left, dp_top, dp_right, dp_bottom;
  logic          dp_whole, dp_overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= RST_MAP_WIDTH;
      map_height    <= RST_MAP_HEIGHT;
      cheap_density <= RST_CHEAP_DENSITY;
      keep_mass     <= RST_KEEP_MASS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:     map_width     <= cfg_data[CW-1:0];
        REG_MAP_HEIGHT:    map_height    <= cfg_data[CW-1:0];
        REG_CHEAP_DENSITY: cheap_density <= cfg_data[DENS_W-1:0];
        REG_KEEP_MASS:     keep_mass     <= cfg_data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  imgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .last     (last),
    .in_stall (in_stall),
    .stat     (stat),
    .out_free (out_free),
    .cmd      (cmd)
  );

  imgt_dp #(
    .MAP_MAX_W   (MAP_MAX_W),
    .MAP_MAX_H   (MAP_MAX_H),
    .PROTECT_MAX (PROTECT_MAX),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .map_width        (map_width),
    .map_height       (map_height),
    .cheap_density    (cheap_density),
    .keep_mass        (keep_mass),
    .weight           (weight),
    .box_left         (box_left),
    .box_top          (box_top),
    .box_right        (box_right),
    .box_bottom       (box_bottom),
    .win_left         (dp_left),
    .win_top          (dp_top),
    .win_right        (dp_right),
    .win_bottom       (dp_bottom),
    .whole_map        (dp_whole),
    .protect_overflow (dp_overflow)
  );

  // Output register: holds a finished transaction while the next map loads.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      win_left         <= dp_left;
      win_top          <= dp_top;
      win_right        <= dp_right;
      win_bottom       <= dp_bottom;
      whole_map        <= dp_whole;
      protect_overflow <= dp_overflow;
    end
  end

  // A trimmed window never collapses: each side keeps at least two cells.
  `IMGT_ASSERT_IMP(a_win_order, out_valid, (win_left < win_right) && (win_top < win_bottom))
  // The whole-map answer always starts at the origin.
  `IMGT_ASSERT_IMP(a_whole_origin, out_valid && whole_map, (win_left == '0) && (win_top == '0))
  // The last cell of a map ends loading, so the input side must stall next.
  `IMGT_ASSERT_NXT(a_last_stalls, in_valid && !in_stall && !func && last, in_stall)

endmodule
